### sv/mtf_pkg.sv
// Shared types and constants for the move-to-front list core.
package mtf_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;
  localparam int COUNT_W = 7;

  // Operation codes carried in the func field
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  // Token handed from one cell to the next while a scan is under way
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] carry;
  } mtf_tok_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic [VALUE_W-1:0] key;
    logic               ins;
    logic               commit;
    logic               abort;
  } mtf_ctl_t;

  // Per-cell report while the token sits in it
  typedef struct packed {
    logic hit;
    logic stop;
  } mtf_stat_t;

endpackage

### sv/mtf_if.sv
// Handshake channels for command items and result items.
interface mtf_cmd_if;
  import mtf_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface mtf_res_if;
  import mtf_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [RANK_W-1:0]  rank;
  logic               full_error;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output found, output rank, output full_error,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input rank, input full_error,
                  input entry_count, output ready);
endinterface

### sv/move_to_front_list_core.sv
// Move-to-front list core: a row of DEPTH cells fed by one scan sequencer.
// After accept the scan token walks the cells until it stops at a hit, at the
// first empty cell (insert or miss) or at the last cell; the finish step then
// issues the result once the result slot is free. A refused insert on a full list
// skips the scan. Only one item is in flight; the token walks one cell per cycle.
// Reset (rst, synchronous) empties the list, clears the count and drops any result.
module move_to_front_list_core
  import mtf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  mtf_cmd_if.sink   cmd,
  mtf_res_if.source res
);

  mtf_tok_t              launch;
  mtf_ctl_t              ctl;
  mtf_stat_t [DEPTH-1:0] stat;
  mtf_tok_t  [DEPTH-1:0] chain;

  mtf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .res    (res),
    .stat   (stat),
    .launch (launch),
    .ctl    (ctl)
  );

  assign chain[0] = launch;

  // Cell row; the last cell's outgoing token falls off the end
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      mtf_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (chain[i]),
        .tok_out (chain[i+1]),
        .ctl     (ctl),
        .stat    (stat[i])
      );
    end else begin : g_last
      mtf_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (chain[i]),
        .tok_out (),
        .ctl     (ctl),
        .stat    (stat[i])
      );
    end
  end

endmodule

### sv/mtf_cell.sv
// One list cell: holds an entry, compares it and passes the shifted value on.
module mtf_cell
  import mtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mtf_tok_t  tok_in,
  output mtf_tok_t  tok_out,
  input  mtf_ctl_t  ctl,
  output mtf_stat_t stat
);

  mtf_tok_t           tok_q;
  logic [VALUE_W-1:0] val;
  logic               valid;
  logic [VALUE_W-1:0] cand;
  logic               pend;

  logic here;
  logic hit;

  // Token present in this cell: compare, stop on hit or at the first empty cell
  assign here = tok_q.vld;
  assign hit  = here && valid && !ctl.ins && (val == ctl.key);

  assign stat.hit  = hit;
  assign stat.stop = here && (hit || !valid);

  // Old entry moves one place back
  assign tok_out.vld   = here && valid && !hit;
  assign tok_out.carry = val;

  // Token register and control state
  always_ff @(posedge clk) begin
    tok_q.carry <= tok_in.carry;
    if (rst) begin
      tok_q.vld <= 1'b0;
      valid     <= 1'b0;
      pend      <= 1'b0;
    end else begin
      tok_q.vld <= tok_in.vld;
      if (here) begin
        pend <= 1'b1;
      end
      if (ctl.commit && pend) begin
        valid <= 1'b1;
      end
      if (ctl.commit || ctl.abort) begin
        pend <= 1'b0;
      end
    end
  end

  // Payload: candidate is held until the scan outcome is known
  always_ff @(posedge clk) begin
    if (here) begin
      cand <= tok_q.carry;
    end
    if (ctl.commit && pend) begin
      val <= cand;
    end
  end

endmodule

### sv/mtf_ctrl.sv
// Sequencer: launches the scan token, collects the outcome and issues results.
module mtf_ctrl
  import mtf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  mtf_cmd_if.sink                cmd,
  mtf_res_if.source              res,
  input  mtf_stat_t [DEPTH-1:0]  stat,
  output mtf_tok_t               launch,
  output mtf_ctl_t               ctl
);

  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]         state;
  logic [POS_W-1:0]   pos;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] key;
  logic               ins;
  logic               hit_q;
  logic [POS_W-1:0]   rank_q;
  logic               full_q;

  logic               res_vld;
  logic               res_found;
  logic [RANK_W-1:0]  res_rank;
  logic               res_full;
  logic [COUNT_W-1:0] res_cnt;

  logic                     accept;
  logic                     full_now;
  logic [DEPTH-1:0]         hit_vec;
  logic [DEPTH-1:0]         stop_vec;
  logic                     any_hit;
  logic                     done;
  logic                     slot_free;
  logic                     fin_go;
  logic [CNT_W-1:0]         cnt_next;
  logic [POS_W+RANK_W-1:0]  rank_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign full_now  = (cnt == CNT_W'(DEPTH));

  // Token enters cell 0 unless the insert is refused
  assign launch.vld   = accept && !(cmd.func == FUNC_INSERT && full_now);
  assign launch.carry = cmd.value;

  // Gather cell reports
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i]  = stat[i].hit;
      stop_vec[i] = stat[i].stop;
    end
  end

  assign any_hit   = |hit_vec;
  assign done      = (|stop_vec) || (pos == POS_W'(DEPTH - 1));
  assign slot_free = !res_vld || res.ready;
  assign fin_go    = (state == ST_FINISH) && slot_free;

  assign ctl.key    = key;
  assign ctl.ins    = ins;
  assign ctl.commit = fin_go && (hit_q || (ins && !full_q));
  assign ctl.abort  = fin_go && !(hit_q || (ins && !full_q));

  assign cnt_next = (ins && !full_q) ? cnt + 1'b1 : cnt;
  assign rank_ext = {{RANK_W{1'b0}}, rank_q};
  assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_next};

  assign res.valid       = res_vld;
  assign res.found       = res_found;
  assign res.rank        = res_rank;
  assign res.full_error  = res_full;
  assign res.entry_count = res_cnt;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      res_vld <= 1'b0;
    end else begin
      // result taken and no new one issued this cycle
      if (res_vld && res.ready && !fin_go) begin
        res_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            key    <= cmd.value;
            ins    <= (cmd.func == FUNC_INSERT);
            pos    <= '0;
            hit_q  <= 1'b0;
            rank_q <= '0;
            if (cmd.func == FUNC_INSERT && full_now) begin
              full_q <= 1'b1;
              state  <= ST_FINISH;
            end else begin
              full_q <= 1'b0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pos <= pos + 1'b1;
          if (done) begin
            hit_q  <= any_hit;
            rank_q <= any_hit ? pos : '0;
            state  <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            res_vld   <= 1'b1;
            res_found <= hit_q;
            res_rank  <= rank_ext[RANK_W-1:0];
            res_full  <= full_q;
            res_cnt   <= cnt_ext[COUNT_W-1:0];
            cnt       <= cnt_next;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Only one cell can hold the token, so at most one cell stops
  a_one_stop: assert property (@(posedge clk) disable iff (rst) $onehot0(stop_vec))
    else $error("more than one cell stopped the scan");

  // An insert never matches
  a_ins_no_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && ins) |-> !any_hit)
    else $error("insert scan reported a hit");

  // Results only leave from the finish step
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_vld) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish");

  // Accepted insert grows the list by one
  a_cnt_inc: assert property (@(posedge clk) disable iff (rst)
    (fin_go && ins && !full_q) |=> cnt == $past(cnt) + 1'b1)
    else $error("entry count did not advance on insert");

  // Count never exceeds the capacity
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> cnt <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

endmodule

### test/move_to_front_list_core_tb.sv
// Testbench for the move-to-front list core: directed edges, fill to capacity, full list, random traffic.
module move_to_front_list_core_tb;
  import mtf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 64;
  localparam int TARGET_ITEMS = 2000;
  localparam int MAX_GAP      = 4;
  // worst item: full scan of the row plus handshake overhead
  localparam int SETTLE_CYCLES = LIST_DEPTH + 16;

  // Expected result of one item
  typedef struct packed {
    logic               found;
    logic [RANK_W-1:0]  rank;
    logic               full_error;
    logic [COUNT_W-1:0] entry_count;
  } mtf_result_t;

  logic clk = 1'b0;
  logic rst;

  mtf_cmd_if cmd_if ();
  mtf_res_if res_if ();

  move_to_front_list_core #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  // Predicted list contents, front at index 0
  logic [VALUE_W-1:0] mtf_list[$];
  mtf_result_t        pending_results[$];
  int                 mismatches  = 0;
  int                 items_sent  = 0;
  bit                 gaps_on     = 1'b1;
  bit                 stalls_on   = 1'b1;

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Apply one item to the predicted list and return what the core should report
  function automatic mtf_result_t predict_mtf(input logic func, input logic [VALUE_W-1:0] value);
    mtf_result_t r;
    int          hit_pos;
    r       = '0;
    hit_pos = -1;
    if (func == FUNC_INSERT) begin
      if (mtf_list.size() >= LIST_DEPTH) begin
        r.full_error = 1'b1;
      end else begin
        mtf_list.push_front(value);
      end
    end else begin
      // first equal entry from the front wins
      for (int i = 0; i < mtf_list.size() && hit_pos < 0; i++) begin
        if (mtf_list[i] == value) hit_pos = i;
      end
      if (hit_pos >= 0) begin
        r.found = 1'b1;
        r.rank  = RANK_W'(hit_pos);
        mtf_list.delete(hit_pos);
        mtf_list.push_front(value);
      end
    end
    r.entry_count = COUNT_W'(mtf_list.size());
    return r;
  endfunction

  // Present one item, wait for it to be taken, then record its prediction
  task automatic send_item(input logic func, input logic [VALUE_W-1:0] value);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.func  <= func;
    cmd_if.value <= value;
    do @(posedge clk); while (!cmd_if.ready);
    pending_results.push_back(predict_mtf(func, value));
    items_sent++;
  endtask

  // Hold the sender off until every outstanding result is back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8) - 4;     // small range, duplicates likely
      1: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] held_value();
    return mtf_list[$urandom_range(0, mtf_list.size() - 1)];
  endfunction

  // Value close to a held one but differing in a single bit, usually a miss
  function automatic logic [VALUE_W-1:0] near_miss_value();
    logic [VALUE_W-1:0] v;
    v = (mtf_list.size() != 0) ? held_value() : $urandom();
    v[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
    return v;
  endfunction

  // Empty list, extreme values, duplicates and the find special cases
  task automatic test_directed_edges();
    send_item(FUNC_FIND,   32'h0000_0000);   // find on an empty list
    send_item(FUNC_INSERT, 32'h8000_0000);
    send_item(FUNC_INSERT, 32'h7FFF_FFFF);
    send_item(FUNC_INSERT, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'hFFFF_FFFF);
    send_item(FUNC_INSERT, 32'hFFFF_FFFF);   // duplicate at the front
    send_item(FUNC_FIND,   32'hFFFF_FFFF);   // front hit, list unchanged
    send_item(FUNC_FIND,   32'h8000_0000);   // hit at the back
    send_item(FUNC_FIND,   32'h7FFF_FFFE);   // miss by one bit
    send_item(FUNC_FIND,   32'h7FFF_FFFF);
    send_item(FUNC_FIND,   32'h0000_0000);
    send_item(FUNC_INSERT, 32'h5555_5555);
    send_item(FUNC_INSERT, 32'hAAAA_AAAA);
    send_item(FUNC_FIND,   32'h5555_5555);
    send_item(FUNC_FIND,   32'hFFFF_FFFF);   // first of two equal entries
    send_item(FUNC_FIND,   32'h1234_5678);
    drain_results();
  endtask

  // Grow the list with mixed traffic until it holds DEPTH entries
  task automatic test_fill_to_capacity();
    int pick;
    while (mtf_list.size() < LIST_DEPTH) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_item(FUNC_INSERT, random_value());
      else if (pick < 85) send_item(FUNC_FIND, held_value());
      else send_item(FUNC_FIND, near_miss_value());
    end
    drain_results();
  endtask

  // Refused inserts and finds at both ends of a full list
  task automatic test_full_list();
    send_item(FUNC_INSERT, 32'h8000_0000);
    send_item(FUNC_INSERT, 32'h7FFF_FFFF);
    send_item(FUNC_FIND,   mtf_list[LIST_DEPTH - 1]);
    send_item(FUNC_FIND,   mtf_list[LIST_DEPTH - 1]);
    send_item(FUNC_FIND,   mtf_list[0]);
    send_item(FUNC_FIND,   near_miss_value());
    send_item(FUNC_INSERT, 32'h0000_0000);
    drain_results();
  endtask

  // Long random run on the full list, idling switched per stretch
  task automatic test_random_traffic();
    int pick;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent % 100 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) send_item(FUNC_FIND, mtf_list[$urandom_range(LIST_DEPTH - 8, LIST_DEPTH - 1)]);
      else if (pick < 70) send_item(FUNC_FIND, held_value());
      else if (pick < 85) send_item(FUNC_FIND, ($urandom_range(0, 1) != 0) ? near_miss_value()
                                                                         : random_value());
      else send_item(FUNC_INSERT, random_value());
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Result side: random stalls, compare each item with the oldest prediction
  initial begin
    int          stall;
    mtf_result_t exp_res;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      repeat (stall) begin
        res_if.ready <= 1'b0;
        @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        if (res_if.found !== exp_res.found)
          report_mismatch($sformatf("found %b, want %b", res_if.found, exp_res.found));
        if (res_if.rank !== exp_res.rank)
          report_mismatch($sformatf("rank %0d, want %0d", res_if.rank, exp_res.rank));
        if (res_if.full_error !== exp_res.full_error)
          report_mismatch($sformatf("full_error %b, want %b", res_if.full_error,
                                    exp_res.full_error));
        if (res_if.entry_count !== exp_res.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d", res_if.entry_count,
                                    exp_res.entry_count));
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("[move_to_front_list_core] ERROR");
    $finish;
  end

  // Sequence of tests
  initial begin
    rst          <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.func  <= FUNC_INSERT;
    cmd_if.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_fill_to_capacity();
    test_full_list();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("[move_to_front_list_core] OK");
    end else begin
      $display("[move_to_front_list_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mtf_pkg.sv
sv/mtf_if.sv
sv/mtf_cell.sv
sv/mtf_ctrl.sv
sv/move_to_front_list_core.sv
test/move_to_front_list_core_tb.sv
